FILE: sv/fsts_pkg.sv
// Package for the fair-share task scheduler.
// Holds the slot count, command codes, controller states and the cell link type.
// No dependencies.
package fsts_pkg;

  localparam int TaskSlots = 16;
  localparam int SlotBits = (TaskSlots > 1) ? $clog2(TaskSlots) : 1;
  localparam int CountBits = $clog2(TaskSlots + 1);
  localparam logic [31:0] GranReset = 32'd1000000;

  typedef enum logic [2:0] {
    CMD_ENQUEUE = 3'd0,
    CMD_DEQUEUE = 3'd1,
    CMD_PICK    = 3'd2,
    CMD_TICK    = 3'd3,
    CMD_YIELD   = 3'd4,
    CMD_PREEMPT = 3'd5,
    CMD_RSVD6   = 3'd6,
    CMD_RSVD7   = 3'd7
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_ADD,
    ST_TEST,
    ST_REMOVE,
    ST_SCAN,
    ST_SCAN_DONE,
    ST_INSERT,
    ST_DONE
  } state_t;

  // Best candidate carried along the cell chain.
  typedef struct packed {
    logic                valid;
    logic [SlotBits-1:0] slot;
    logic [63:0]         vrt;
    logic [31:0]         age;
  } lead_t;

endpackage

FILE: sv/fsts_cell.sv
// One slot cell of the leader chain: compares its own entry with the incoming best.
// Depends on fsts_pkg.
module fsts_cell import fsts_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic                queued,
  input  logic [SlotBits-1:0] slot,
  input  logic [63:0]         vrt,
  input  logic [31:0]         age,
  input  lead_t               lead_in,
  output lead_t               lead_out
);

  lead_t best_next;

  always_comb begin
    best_next = lead_in;
    if (queued) begin
      if (!lead_in.valid || vrt < lead_in.vrt ||
          (vrt == lead_in.vrt && age > lead_in.age)) begin
        best_next.valid = 1'b1;
        best_next.slot = slot;
        best_next.vrt = vrt;
        best_next.age = age;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_out.valid <= 1'b0;
    end else if (load) begin
      lead_out.valid <= best_next.valid;
    end
    if (load) begin
      lead_out.slot <= best_next.slot;
      lead_out.vrt <= best_next.vrt;
      lead_out.age <= best_next.age;
    end
  end

endmodule

FILE: sv/fsts_div.sv
// Restoring divider for the tick charge, one quotient bit per cycle.
// Computes floor(delta*1024/w) saturated to 64 bits. Depends on fsts_pkg.
module fsts_div import fsts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] delta,
  input  logic [16:0] weight,
  output logic        done,
  output logic [63:0] charge
);

  logic [73:0] dividend;
  logic [16:0] divisor;
  logic [17:0] rem;
  logic [73:0] quot;
  logic [6:0]  cnt;
  logic        active;
  logic [17:0] trial;
  logic [17:0] shifted;

  assign shifted = {rem[16:0], dividend[73]};
  assign trial = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active <= 1'b1;
      end else if (active && cnt == 7'd73) begin
        active <= 1'b0;
        done <= 1'b1;
      end
    end
    if (go) begin
      dividend <= {delta, 10'd0};
      divisor <= (weight == 17'd0) ? 17'd1 : weight;
      rem <= 18'd0;
      quot <= 74'd0;
      cnt <= 7'd0;
    end else if (active) begin
      dividend <= {dividend[72:0], 1'b0};
      cnt <= cnt + 7'd1;
      if (!trial[17]) begin
        rem <= trial;
        quot <= {quot[72:0], 1'b1};
      end else begin
        rem <= shifted;
        quot <= {quot[72:0], 1'b0};
      end
    end
  end

  assign charge = (quot[73:64] != 10'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : quot[63:0];

endmodule

FILE: sv/fair_share_task_scheduler.sv
// Fair-share task scheduler top level over TaskSlots slots; depends on fsts_pkg, fsts_cell, fsts_div.
// Each request goes from a read state to a done state before the strobe; a new enqueue inserts,
// pick and preempt check scan the cell chain, dequeue removes and rescans, and a move also reinserts.
// A tick waits for the divider and adds the charge, then moves the task if it exceeds min + gran.
// One request at a time: busy is high until the strobe cycle, so requests never overlap.
// The receiver cannot stall. Synchronous reset clears the queue and vruntimes, not the slot stamps.
module fair_share_task_scheduler import fsts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd,
  input  logic [3:0]  task_id,
  input  logic [63:0] now_time,
  input  logic [16:0] load_weight,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output logic        done,
  output logic        found,
  output logic [3:0]  picked_task,
  output logic        may_preempt,
  output logic [4:0]  queued_count,
  output logic [63:0] queue_min_vruntime,
  output logic [63:0] task_vruntime
);

  state_t state, state_next;

  logic [31:0] gran;
  logic [63:0] slot_vrt [TaskSlots];
  logic [63:0] slot_start [TaskSlots];
  logic [31:0] slot_stamp [TaskSlots];
  logic [TaskSlots-1:0] slot_q;
  logic [31:0] next_stamp;
  logic [63:0] min_vrt;
  logic [CountBits-1:0] run_cnt;

  cmd_t cur_cmd;
  logic [3:0] cur_tid;
  logic [63:0] cur_now;
  logic [16:0] cur_w;
  logic valid_tid;
  logic [SlotBits-1:0] s;
  logic [63:0] vrt_s;
  logic [63:0] delta;
  logic [63:0] charge;
  logic div_go;
  logic div_done;
  logic [SlotBits:0] scan_cnt;
  logic scan_for_remove;
  logic res_found;
  logic [3:0] res_pick;
  logic res_pre;

  lead_t link [TaskSlots+1];

  assign link[0] = '0;

  for (genvar i = 0; i < TaskSlots; i++) begin : g_cell
    fsts_cell u_cell (
      .clk(clk),
      .rst(rst),
      .load(state == ST_SCAN),
      .queued(slot_q[i]),
      .slot(SlotBits'(i)),
      .vrt(slot_vrt[i]),
      .age(next_stamp - slot_stamp[i]),
      .lead_in(link[i]),
      .lead_out(link[i+1])
    );
  end

  fsts_div u_div (
    .clk(clk),
    .rst(rst),
    .go(div_go),
    .delta(delta),
    .weight(cur_w),
    .done(div_done),
    .charge(charge)
  );

  assign valid_tid = ({28'd0, cur_tid} < 32'(TaskSlots));
  assign s = cur_tid[SlotBits-1:0];
  assign vrt_s = slot_vrt[s];
  assign delta = cur_now - slot_start[s];
  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_READ;
      ST_READ: begin
        unique case (cur_cmd)
          CMD_ENQUEUE: state_next = !valid_tid ? ST_DONE
                                  : (slot_q[s] ? ST_REMOVE : ST_INSERT);
          CMD_DEQUEUE: state_next = (valid_tid && slot_q[s]) ? ST_REMOVE : ST_DONE;
          CMD_PICK: state_next = (run_cnt != '0) ? ST_SCAN : ST_DONE;
          CMD_TICK: state_next = (valid_tid && delta != 64'd0) ? ST_DIV : ST_DONE;
          CMD_YIELD: state_next = (valid_tid && slot_q[s]) ? ST_REMOVE : ST_DONE;
          CMD_PREEMPT: state_next = (valid_tid && run_cnt != '0) ? ST_SCAN : ST_DONE;
          default: state_next = ST_DONE;
        endcase
      end
      ST_DIV: if (div_done) state_next = ST_ADD;
      ST_ADD: state_next = ST_TEST;
      ST_TEST: state_next = (slot_q[s] && vrt_s > min_vrt && (vrt_s - min_vrt) > {32'd0, gran})
                            ? ST_REMOVE : ST_DONE;
      ST_REMOVE: state_next = ST_SCAN;
      ST_SCAN: if (scan_cnt == (SlotBits+1)'(TaskSlots - 1)) state_next = ST_SCAN_DONE;
      ST_SCAN_DONE: state_next = scan_for_remove
                                 ? ((cur_cmd == CMD_DEQUEUE) ? ST_DONE : ST_INSERT) : ST_DONE;
      ST_INSERT: state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign div_go = (state == ST_READ) && (state_next == ST_DIV);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      gran <= GranReset;
      slot_q <= '0;
      next_stamp <= 32'd0;
      min_vrt <= 64'd0;
      run_cnt <= '0;
      done <= 1'b0;
      for (int i = 0; i < TaskSlots; i++) begin
        slot_vrt[i] <= 64'd0;
        slot_start[i] <= 64'd0;
      end
    end else begin
      state <= state_next;
      done <= (state == ST_DONE);
      if (cfg_we) gran <= cfg_wdata;
      unique case (state)
        ST_IDLE: begin
          res_found <= 1'b0;
          res_pick <= 4'd0;
          res_pre <= 1'b0;
          scan_for_remove <= 1'b0;
          if (start) begin
            cur_cmd <= cmd_t'(cmd);
            cur_tid <= task_id;
            cur_now <= now_time;
            cur_w <= load_weight;
          end
        end
        ST_READ: scan_cnt <= '0;
        ST_ADD: begin
          slot_start[s] <= cur_now;
          slot_vrt[s] <= (vrt_s > ~charge) ? 64'hFFFF_FFFF_FFFF_FFFF : vrt_s + charge;
        end
        ST_REMOVE: begin
          slot_q[s] <= 1'b0;
          scan_for_remove <= 1'b1;
          scan_cnt <= '0;
          if (run_cnt != '0) run_cnt <= run_cnt - CountBits'(1);
        end
        ST_SCAN: scan_cnt <= scan_cnt + (SlotBits+1)'(1);
        ST_SCAN_DONE: begin
          if (scan_for_remove) begin
            if (link[TaskSlots].valid) min_vrt <= link[TaskSlots].vrt;
          end else if (cur_cmd == CMD_PICK) begin
            res_found <= link[TaskSlots].valid;
            res_pick <= link[TaskSlots].valid ? 4'(link[TaskSlots].slot) : 4'd0;
          end else begin
            res_pre <= link[TaskSlots].valid && link[TaskSlots].slot != s &&
                       vrt_s > link[TaskSlots].vrt &&
                       (vrt_s - link[TaskSlots].vrt) > {32'd0, gran};
          end
        end
        ST_INSERT: begin
          if (vrt_s == 64'd0) begin
            slot_vrt[s] <= min_vrt;
          end else if (vrt_s < min_vrt) begin
            min_vrt <= vrt_s;
          end
          slot_q[s] <= 1'b1;
          slot_stamp[s] <= next_stamp;
          next_stamp <= next_stamp + 32'd1;
          if (run_cnt != CountBits'(TaskSlots)) run_cnt <= run_cnt + CountBits'(1);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    found = done & res_found;
    picked_task = done ? res_pick : 4'd0;
    may_preempt = done & res_pre;
    queued_count = 5'(run_cnt);
    queue_min_vruntime = min_vrt;
    task_vruntime = valid_tid ? vrt_s : 64'd0;
  end

endmodule

FILE: sv/fsts_checker.sv
// Port-level checker for the fair-share task scheduler, bound to the top level.
// Depends on fsts_pkg.
module fsts_checker import fsts_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic       found,
  input logic       may_preempt,
  input logic [4:0] queued_count
);

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request not taken");
  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("strobe while busy");
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(found && may_preempt)) else $error("found and preempt together");
  a_found_strobe: assert property (@(posedge clk) disable iff (rst)
    found |-> done && queued_count != 5'd0) else $error("found without queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    queued_count <= 5'(TaskSlots)) else $error("count out of range");

endmodule

bind fair_share_task_scheduler fsts_checker u_fsts_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done),
  .found(found),
  .may_preempt(may_preempt),
  .queued_count(queued_count)
);
